// ----- rtl/arm_servo_angle_mapper_defines.svh -----
// ----------------------------------------------------------------------------
// Arm servo angle mapper assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARM_SERVO_ANGLE_MAPPER_DEFINES_SVH
`define ARM_SERVO_ANGLE_MAPPER_DEFINES_SVH

// same-cycle implication
`define ASM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("servo mapper check failed");

// next-cycle implication
`define ASM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("servo mapper check failed");

`endif

// ----- rtl/asm_pkg.sv -----
// ----------------------------------------------------------------------------
// Arm servo angle mapper package
// Queue word type, joint limits and small joint mapping functions.
// ----------------------------------------------------------------------------
package asm_pkg;

  localparam logic [11:0] GripKnee      = 12'd1947;
  localparam logic [6:0]  GripMax       = 7'd50;
  // 46 * ceil(2^27 / 2148): exact floor(d * 46 / 2148) for d up to 2148
  localparam logic [21:0] GripRecip     = 22'd2874310;
  localparam int          GripShift     = 27;
  // 23 * ceil(2^16 / 34): exact floor(t * 115 / 170) for t up to 170
  localparam logic [15:0] PitchRecip    = 16'd44344;
  localparam logic [13:0] TiltOffset    = 14'd1440;

  localparam logic [7:0]  JointMin      = 8'd5;
  localparam logic [7:0]  WideMax       = 8'd175;
  localparam logic [7:0]  WideDeadLo    = 8'd86;
  localparam logic [7:0]  WideDeadHi    = 8'd93;
  localparam logic [7:0]  WideCentre    = 8'd90;
  localparam logic [7:0]  ShoulderMax   = 8'd85;
  localparam logic [7:0]  ShoulderDeadLo = 8'd42;
  localparam logic [7:0]  ShoulderDeadHi = 8'd48;
  localparam logic [6:0]  ShoulderCentre = 7'd45;
  localparam logic [6:0]  ElbowMin      = 7'd5;
  localparam logic [6:0]  ElbowMax      = 7'd120;
  localparam logic [6:0]  ElbowWindow   = 7'd7;
  localparam logic [6:0]  ElbowCentre   = 7'd45;

  typedef struct packed {
    logic [5:0] gripper;
    logic [7:0] wide;      // waist in mode 0, wrist roll in mode 1
    logic [7:0] pitch;     // live wrist pitch
    logic [6:0] shoulder;  // live shoulder
    logic [6:0] elbow_sh;  // elbow mapped from live shoulder
    logic [6:0] elbow_wp;  // elbow mapped from live wrist pitch, unwindowed
    logic       mode;
  } asm_item_t;

  function automatic logic [7:0] wide_joint(input logic neg, input logic [8:0] v);
    logic [7:0] r;
    if (neg || v < {1'b0, JointMin}) r = JointMin;
    else if (v > {1'b0, WideMax}) r = WideMax;
    else r = v[7:0];
    if (r >= WideDeadLo && r <= WideDeadHi) r = WideCentre;
    return r;
  endfunction

  function automatic logic [6:0] shoulder_joint(input logic neg, input logic [7:0] v);
    logic [7:0] r;
    if (neg || v < JointMin) r = JointMin;
    else if (v > ShoulderMax) r = ShoulderMax;
    else r = v;
    if (r >= ShoulderDeadLo && r <= ShoulderDeadHi) r = {1'b0, ShoulderCentre};
    return r[6:0];
  endfunction

  // 120 - floor((s - 5) * 115 / 80), and 115 / 80 = 23 / 16
  function automatic logic [6:0] elbow_from_shoulder(input logic [6:0] s);
    logic [6:0]  t;
    logic [10:0] p;
    t = s - ElbowMin;
    p = 11'(t) * 11'd23;
    return ElbowMax - p[10:4];
  endfunction

endpackage

// ----- rtl/asm_front.sv -----
// ----------------------------------------------------------------------------
// Arm servo angle mapper front end
// Maps one sensor word into live joint candidates for the queue.
// ----------------------------------------------------------------------------
module asm_front (
  input  logic [11:0]       stick_raw_i,
  input  logic [12:0]       pitch_q4_i,
  input  logic [12:0]       roll_q4_i,
  input  logic              hold_mode_i,
  output asm_pkg::asm_item_t item_o
);
  import asm_pkg::*;

  logic [11:0] grip_d;
  logic [33:0] grip_prod;
  logic [6:0]  grip_q;
  logic [6:0]  grip_val;
  logic [13:0] pitch_n;
  logic [13:0] roll_n;
  logic [7:0]  pitch_live;
  logic [6:0]  shoulder_cand;
  logic [7:0]  wp_t;
  logic [23:0] wp_prod;

  assign grip_d    = (stick_raw_i > GripKnee) ? (stick_raw_i - GripKnee) : 12'd0;
  assign grip_prod = 34'(grip_d) * 34'(GripRecip);
  assign grip_q    = grip_prod[33:GripShift];
  assign grip_val  = GripMax - grip_q;

  // negative sums truncate toward zero, then clamp to the joint floor
  assign pitch_n = {pitch_q4_i[12], pitch_q4_i} + TiltOffset;
  assign roll_n  = {roll_q4_i[12], roll_q4_i} + TiltOffset;

  assign pitch_live    = wide_joint(roll_n[13], roll_n[12:4]);
  assign shoulder_cand = shoulder_joint(roll_n[13], roll_n[12:5]);

  assign wp_t    = pitch_live - JointMin;
  assign wp_prod = 24'(wp_t) * 24'(PitchRecip);

  always_comb begin
    item_o          = '0;
    item_o.gripper  = grip_val[5:0];
    item_o.wide     = wide_joint(pitch_n[13], pitch_n[12:4]);
    item_o.pitch    = pitch_live;
    item_o.shoulder = shoulder_cand;
    item_o.elbow_sh = elbow_from_shoulder(shoulder_cand);
    item_o.elbow_wp = ElbowMin + wp_prod[22:16];
    item_o.mode     = hold_mode_i;
  end

endmodule

// ----- rtl/asm_queue.sv -----
// ----------------------------------------------------------------------------
// Arm servo angle mapper queue
// Two-entry word queue between the front end and the hold logic.
// ----------------------------------------------------------------------------
module asm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  asm_pkg::asm_item_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output asm_pkg::asm_item_t rdata_o
);
  import asm_pkg::*;

  asm_item_t   mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/asm_back.sv -----
// ----------------------------------------------------------------------------
// Arm servo angle mapper back end
// Applies mode holds and the elbow window, drives the output register.
// ----------------------------------------------------------------------------
module asm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  asm_pkg::asm_item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         gripper_angle_o,
  output logic [7:0]         waist_angle_o,
  output logic [6:0]         shoulder_angle_o,
  output logic [6:0]         elbow_angle_o,
  output logic [7:0]         wrist_roll_angle_o,
  output logic [7:0]         wrist_pitch_angle_o
);
  import asm_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [5:0] gripper_q;
  logic [7:0] waist_q, waist_d;
  logic [6:0] shoulder_q, shoulder_d;
  logic [6:0] elbow_q, elbow_d;
  logic [7:0] wroll_q, wroll_d;
  logic [7:0] wpitch_q, wpitch_d;

  logic [7:0] waist_held_q, waist_keep;
  logic [6:0] shoulder_held_q, shoulder_keep;
  logic [7:0] wroll_held_q, wroll_keep;
  logic [7:0] wpitch_held_q, wpitch_keep;
  logic [6:0] centre_q, centre;
  logic [7:0] last_waist_q;
  logic [6:0] last_shoulder_q;
  logic [7:0] last_wroll_q;
  logic [7:0] last_wpitch_q;
  logic       last_mode_q;

  logic       rise, fall, take;
  logic [6:0] lo, hi;

  assign take        = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = take;
  assign out_valid_d = take || (out_valid_q && out_stall_i);

  assign rise = !last_mode_q && q_item_i.mode;
  assign fall = last_mode_q && !q_item_i.mode;

  // a mode edge latches the previous outputs as the new holds
  assign waist_keep    = rise ? last_waist_q : waist_held_q;
  assign shoulder_keep = rise ? last_shoulder_q : shoulder_held_q;
  assign centre        = rise ? elbow_from_shoulder(last_shoulder_q) : centre_q;
  assign wroll_keep    = fall ? last_wroll_q : wroll_held_q;
  assign wpitch_keep   = fall ? last_wpitch_q : wpitch_held_q;

  assign lo = (centre < ElbowMin + ElbowWindow) ? ElbowMin : centre - ElbowWindow;
  assign hi = (centre > ElbowMax - ElbowWindow) ? ElbowMax : centre + ElbowWindow;

  always_comb begin
    if (!q_item_i.mode) begin
      waist_d    = q_item_i.wide;
      shoulder_d = q_item_i.shoulder;
      elbow_d    = q_item_i.elbow_sh;
      wroll_d    = wroll_keep;
      wpitch_d   = wpitch_keep;
    end else begin
      waist_d    = waist_keep;
      shoulder_d = shoulder_keep;
      wroll_d    = q_item_i.wide;
      wpitch_d   = q_item_i.pitch;
      if (q_item_i.elbow_wp < lo) elbow_d = lo;
      else if (q_item_i.elbow_wp > hi) elbow_d = hi;
      else elbow_d = q_item_i.elbow_wp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      waist_held_q    <= WideCentre;
      shoulder_held_q <= ShoulderCentre;
      wroll_held_q    <= WideCentre;
      wpitch_held_q   <= WideCentre;
      centre_q        <= ElbowCentre;
      last_waist_q    <= WideCentre;
      last_shoulder_q <= ShoulderCentre;
      last_wroll_q    <= WideCentre;
      last_wpitch_q   <= WideCentre;
      last_mode_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        waist_held_q    <= waist_keep;
        shoulder_held_q <= shoulder_keep;
        wroll_held_q    <= wroll_keep;
        wpitch_held_q   <= wpitch_keep;
        centre_q        <= centre;
        last_waist_q    <= waist_d;
        last_shoulder_q <= shoulder_d;
        last_wroll_q    <= wroll_d;
        last_wpitch_q   <= wpitch_d;
        last_mode_q     <= q_item_i.mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      gripper_q  <= q_item_i.gripper;
      waist_q    <= waist_d;
      shoulder_q <= shoulder_d;
      elbow_q    <= elbow_d;
      wroll_q    <= wroll_d;
      wpitch_q   <= wpitch_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign gripper_angle_o     = gripper_q;
  assign waist_angle_o       = waist_q;
  assign shoulder_angle_o    = shoulder_q;
  assign elbow_angle_o       = elbow_q;
  assign wrist_roll_angle_o  = wroll_q;
  assign wrist_pitch_angle_o = wpitch_q;

endmodule

// ----- rtl/arm_servo_angle_mapper.sv -----
// An accepted word is queued, then registered at the outputs when the back end takes it.
// One word per cycle if out_stall_i is low; the 2-entry queue lets either side stall alone.
// Input stalls only when the queue holds two words behind a stalled output word.
// Reset (rst_ni low, asynchronous) empties the queue, drops the output word and
// returns holds to waist 90, shoulder 45, wrists 90, elbow centre 45, mode 0.
// ----------------------------------------------------------------------------
// Arm servo angle mapper
// Maps stick, pitch and roll readings to six servo angles with mode holds.
// ----------------------------------------------------------------------------
module arm_servo_angle_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] stick_raw_i,
  input  logic [12:0] pitch_q4_i,
  input  logic [12:0] roll_q4_i,
  input  logic        hold_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  gripper_angle_o,
  output logic [7:0]  waist_angle_o,
  output logic [6:0]  shoulder_angle_o,
  output logic [6:0]  elbow_angle_o,
  output logic [7:0]  wrist_roll_angle_o,
  output logic [7:0]  wrist_pitch_angle_o
);
  import asm_pkg::*;

  asm_item_t front_item;
  asm_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      push;

  assign push       = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  asm_front u_front (
    .stick_raw_i (stick_raw_i),
    .pitch_q4_i  (pitch_q4_i),
    .roll_q4_i   (roll_q4_i),
    .hold_mode_i (hold_mode_i),
    .item_o      (front_item)
  );

  asm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  asm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_item_i            (q_item),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .gripper_angle_o     (gripper_angle_o),
    .waist_angle_o       (waist_angle_o),
    .shoulder_angle_o    (shoulder_angle_o),
    .elbow_angle_o       (elbow_angle_o),
    .wrist_roll_angle_o  (wrist_roll_angle_o),
    .wrist_pitch_angle_o (wrist_pitch_angle_o)
  );

endmodule

// ----- rtl/asm_checker.sv -----
// ----------------------------------------------------------------------------
// Arm servo angle mapper checker
// Port-level checks on output word ranges, deadbands and stall behavior.
// ----------------------------------------------------------------------------
`include "arm_servo_angle_mapper_defines.svh"

module asm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [11:0] stick_raw_i,
  input logic [12:0] pitch_q4_i,
  input logic [12:0] roll_q4_i,
  input logic        hold_mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  gripper_angle_o,
  input logic [7:0]  waist_angle_o,
  input logic [6:0]  shoulder_angle_o,
  input logic [6:0]  elbow_angle_o,
  input logic [7:0]  wrist_roll_angle_o,
  input logic [7:0]  wrist_pitch_angle_o
);

  // hold a stalled output word
  `ASM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(elbow_angle_o) && $stable(waist_angle_o) && $stable(gripper_angle_o))

  `ASM_ASSERT_NOW(a_narrow_range, out_valid_o, gripper_angle_o >= 6'd4 && gripper_angle_o <= 6'd50 && elbow_angle_o >= 7'd5 && elbow_angle_o <= 7'd120 && shoulder_angle_o >= 7'd5 && shoulder_angle_o <= 7'd85)

  `ASM_ASSERT_NOW(a_wide_dead, out_valid_o, (waist_angle_o < 8'd86 || waist_angle_o > 8'd93 || waist_angle_o == 8'd90) && (wrist_roll_angle_o < 8'd86 || wrist_roll_angle_o > 8'd93 || wrist_roll_angle_o == 8'd90) && (wrist_pitch_angle_o < 8'd86 || wrist_pitch_angle_o > 8'd93 || wrist_pitch_angle_o == 8'd90))

  `ASM_ASSERT_NOW(a_shoulder_dead, out_valid_o, shoulder_angle_o < 7'd42 || shoulder_angle_o > 7'd48 || shoulder_angle_o == 7'd45)

endmodule

bind arm_servo_angle_mapper asm_checker u_asm_checker (.*);
